// ===== src/uac_pkg.sv =====
`default_nettype none
package uac_pkg;

    // alphabet sizes and ceil(2^16 / m) for the remainder step
    localparam logic [5:0]  RU_M        = 6'd33;
    localparam logic [5:0]  EN_M        = 6'd26;
    localparam logic [11:0] RU_RECIP    = 12'd1986;
    localparam logic [11:0] EN_RECIP    = 12'd2521;
    localparam int          RECIP_SHIFT = 16;

    // Cyrillic code points (lower and upper case), yo sits at index 6
    localparam logic [10:0] RU_LO_BASE = 11'h430;
    localparam logic [10:0] RU_LO_YO   = 11'h451;
    localparam logic [10:0] RU_UP_BASE = 11'h410;
    localparam logic [10:0] RU_UP_YO   = 11'h401;
    localparam logic [5:0]  RU_YO_IDX  = 6'd6;

    localparam logic [7:0] ASCII_LO_A = 8'h61;
    localparam logic [7:0] ASCII_UP_A = 8'h41;

    // configuration register indexes
    localparam logic [1:0] CFG_DECRYPT = 2'd0;
    localparam logic [1:0] CFG_LANG    = 2'd1;
    localparam logic [1:0] CFG_MULT    = 2'd2;
    localparam logic [1:0] CFG_SHIFT   = 2'd3;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;

    typedef struct packed {
        logic       decrypt_mode;
        logic       language;
        logic [5:0] mult_key;
        logic [5:0] shift_key;
    } cfg_t;

    // one character request: bytes, count - 1, flags, alphabet index
    typedef struct packed {
        logic [3:0][7:0] data;
        logic [1:0]      cnt;
        logic            last;
        logic            letter;
        logic            upper;
        logic [5:0]      idx;
    } req_t;

endpackage
`default_nettype wire

// ===== src/utf8_affine_cipher_ru_en.sv =====
`default_nettype none
// Affine cipher over a UTF-8 byte stream, one byte per cycle in both directions
// while full is low and pop is held. Bytes are grouped into characters by their
// lead byte; a character leaves only once its last byte (or a byte marked
// in_last) has come in. The edge that takes its last input byte writes the
// character queue; the product stage, quotient stage and output register follow
// before its first output byte is on the result ports. Letters of the selected
// alphabet (Russian 33 with yo, or English 26) are mapped with a*x+b or
// inv*(x-b) modulo the alphabet size; anything else passes unchanged. A
// four-entry character queue sits between the byte assembler and the mapping
// pipeline, so input keeps flowing while the output side stalls. key_bad is set
// on every byte when the multiplier has no inverse. Configuration writes are
// always taken (cfg_ready is tied high) and must be made while the block is idle.
module utf8_affine_cipher_ru_en (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    output logic            full,
    input  wire logic [7:0] in_byte,
    input  wire logic       in_last,
    output logic            empty,
    input  wire logic       pop,
    output logic [7:0]      out_byte,
    output logic            run_last,
    output logic            stream_end,
    output logic            key_bad,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [1:0] cfg_index,
    input  wire logic [5:0] cfg_data
);

    uac_pkg::cfg_t cfg_reg;
    uac_pkg::req_t front_req, q_req;
    logic          acc, emit, q_valid, q_pop;

    assign cfg_ready = 1'b1;
    assign acc       = push && !full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.decrypt_mode <= 1'b0;
            cfg_reg.language     <= 1'b0;
            cfg_reg.mult_key     <= 6'd1;
            cfg_reg.shift_key    <= 6'd0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                uac_pkg::CFG_DECRYPT: cfg_reg.decrypt_mode <= cfg_data[0];
                uac_pkg::CFG_LANG:    cfg_reg.language     <= cfg_data[0];
                uac_pkg::CFG_MULT:    cfg_reg.mult_key     <= cfg_data;
                uac_pkg::CFG_SHIFT:   cfg_reg.shift_key    <= cfg_data;
                default:              cfg_reg.shift_key    <= cfg_reg.shift_key;
            endcase
        end
    end

    uac_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .acc      (acc),
        .in_byte  (in_byte),
        .in_last  (in_last),
        .language (cfg_reg.language),
        .emit     (emit),
        .req      (front_req)
    );

    uac_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (emit),
        .wr_req (front_req),
        .rd_en  (q_pop),
        .full   (full),
        .valid  (q_valid),
        .rd_req (q_req)
    );

    uac_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .q_valid    (q_valid),
        .q_req      (q_req),
        .q_pop      (q_pop),
        .empty      (empty),
        .pop        (pop),
        .out_byte   (out_byte),
        .run_last   (run_last),
        .stream_end (stream_end),
        .key_bad    (key_bad)
    );

endmodule
`default_nettype wire

// ===== src/uac_front.sv =====
`default_nettype none
module uac_front (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         acc,
    input  wire logic [7:0]   in_byte,
    input  wire logic         in_last,
    input  wire logic         language,
    output logic              emit,
    output uac_pkg::req_t     req
);

    logic [7:0] pend_reg [3];
    logic [1:0] held_reg, held_next;
    logic [2:0] exp_reg, exp_next;

    logic [2:0]  len;
    logic        complete;
    logic        hold;
    logic [3:0][7:0] buf_data;
    logic [10:0] cp;
    logic [10:0] off_lo, off_up;
    logic        en_lo, en_up, ru_ok;

    function automatic logic [2:0] lead_len(input logic [7:0] c);
        logic [2:0] r;
        r = 3'd1;
        if (c[7:5] == 3'b110)
            r = 3'd2;
        else if (c[7:4] == 4'b1110)
            r = 3'd3;
        else if (c[7:3] == 5'b11110)
            r = 3'd4;
        return r;
    endfunction

    always_comb
    begin
        len = lead_len(in_byte);
        buf_data[0] = pend_reg[0];
        buf_data[1] = pend_reg[1];
        buf_data[2] = pend_reg[2];
        buf_data[3] = 8'h00;
        buf_data[held_reg] = in_byte;
        if (held_reg == 2'd0)
            complete = (len == 3'd1);
        else
            complete = ({1'b0, held_reg} + 3'd1) >= exp_reg;
        hold = !complete && !in_last;
        emit = acc && !hold;
    end

    // letter classification of the assembled character
    always_comb
    begin
        cp     = {buf_data[0][4:0], buf_data[1][5:0]};
        off_lo = cp - uac_pkg::RU_LO_BASE;
        off_up = cp - uac_pkg::RU_UP_BASE;
        en_lo  = buf_data[0] >= 8'h61 && buf_data[0] <= 8'h7A;
        en_up  = buf_data[0] >= 8'h41 && buf_data[0] <= 8'h5A;
        ru_ok  = (buf_data[0] == 8'hD0 || buf_data[0] == 8'hD1)
                 && buf_data[1][7:6] == 2'b10;

        req.data   = buf_data;
        req.cnt    = held_reg;
        req.last   = in_last;
        req.letter = 1'b0;
        req.upper  = 1'b0;
        req.idx    = 6'd0;
        if (complete && language && held_reg == 2'd0)
        begin
            if (en_lo)
            begin
                req.letter = 1'b1;
                req.idx    = 6'(buf_data[0] - uac_pkg::ASCII_LO_A);
            end
            else if (en_up)
            begin
                req.letter = 1'b1;
                req.upper  = 1'b1;
                req.idx    = 6'(buf_data[0] - uac_pkg::ASCII_UP_A);
            end
        end
        else if (complete && !language && held_reg == 2'd1 && ru_ok)
        begin
            if (cp == uac_pkg::RU_LO_YO)
            begin
                req.letter = 1'b1;
                req.idx    = uac_pkg::RU_YO_IDX;
            end
            else if (off_lo < 11'd6)
            begin
                req.letter = 1'b1;
                req.idx    = off_lo[5:0];
            end
            else if (off_lo < 11'd32)
            begin
                req.letter = 1'b1;
                req.idx    = off_lo[5:0] + 6'd1;
            end
            else if (cp == uac_pkg::RU_UP_YO)
            begin
                req.letter = 1'b1;
                req.upper  = 1'b1;
                req.idx    = uac_pkg::RU_YO_IDX;
            end
            else if (off_up < 11'd6)
            begin
                req.letter = 1'b1;
                req.upper  = 1'b1;
                req.idx    = off_up[5:0];
            end
            else if (off_up < 11'd32)
            begin
                req.letter = 1'b1;
                req.upper  = 1'b1;
                req.idx    = off_up[5:0] + 6'd1;
            end
        end
    end

    always_comb
    begin
        held_next = held_reg;
        exp_next  = exp_reg;
        if (acc)
        begin
            if (hold)
            begin
                held_next = held_reg + 2'd1;
                if (held_reg == 2'd0)
                    exp_next = len;
            end
            else
            begin
                held_next = 2'd0;
                exp_next  = 3'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg <= 2'd0;
            exp_reg  <= 3'd0;
        end
        else
        begin
            held_reg <= held_next;
            exp_reg  <= exp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc && hold && held_reg != 2'd3)
            pend_reg[held_reg] <= in_byte;
    end

endmodule
`default_nettype wire

// ===== src/uac_queue.sv =====
`default_nettype none
module uac_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          wr_en,
    input  wire uac_pkg::req_t wr_req,
    input  wire logic          rd_en,
    output logic               full,
    output logic               valid,
    output uac_pkg::req_t      rd_req
);

    uac_pkg::req_t mem_reg [uac_pkg::QDEPTH];
    logic [uac_pkg::QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [uac_pkg::QPTR_W:0]   count_reg, count_next;

    assign full   = count_reg == (uac_pkg::QPTR_W+1)'(uac_pkg::QDEPTH);
    assign valid  = count_reg != '0;
    assign rd_req = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (wr_en && !rd_en)
            count_next = count_reg + 1'b1;
        else if (!wr_en && rd_en)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (rd_en)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem_reg[wr_ptr_reg] <= wr_req;
    end

endmodule
`default_nettype wire

// ===== src/uac_back.sv =====
`default_nettype none
module uac_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire uac_pkg::cfg_t cfg,
    input  wire logic          q_valid,
    input  wire uac_pkg::req_t q_req,
    output logic               q_pop,
    output logic               empty,
    input  wire logic          pop,
    output logic [7:0]         out_byte,
    output logic               run_last,
    output logic               stream_end,
    output logic               key_bad
);

    // stage 1: affine product, stage 2: quotient, then byte serializer
    logic            s1_v_reg;
    uac_pkg::req_t   s1_req_reg;
    logic            s1_bad_reg;
    logic [10:0]     s1_val_reg;

    logic            s2_v_reg;
    uac_pkg::req_t   s2_req_reg;
    logic            s2_bad_reg;
    logic [10:0]     s2_val_reg;
    logic [5:0]      s2_quo_reg;

    logic            ser_v_reg;
    logic [3:0][7:0] ser_data_reg;
    logic [1:0]      ser_cnt_reg;
    logic [1:0]      ser_pos_reg;
    logic            ser_last_reg;
    logic            ser_bad_reg;

    logic        s1_ready, s2_ready, ser_load, pop_fire, at_end;
    logic [5:0]  m, a, b, inv, k, xp, addend;
    logic [6:0]  xs;
    logic [11:0] prod;
    logic [10:0] val;
    logic [22:0] rprod;
    logic [11:0] qm;
    logic [5:0]  y;
    logic [10:0] cp_out, base, yo;
    logic [3:0][7:0] enc;

    function automatic logic [5:0] reduce(input logic [5:0] v, input logic en);
        logic [5:0] r;
        r = v;
        if (en)
        begin
            if (v >= 6'd52)
                r = v - 6'd52;
            else if (v >= uac_pkg::EN_M)
                r = v - uac_pkg::EN_M;
        end
        else if (v >= uac_pkg::RU_M)
            r = v - uac_pkg::RU_M;
        return r;
    endfunction

    // zero means no inverse exists
    function automatic logic [5:0] inv_of(input logic [5:0] v, input logic en);
        logic [5:0] r;
        r = 6'd0;
        if (en)
        begin
            case (v)
                6'd1:    r = 6'd1;
                6'd3:    r = 6'd9;
                6'd5:    r = 6'd21;
                6'd7:    r = 6'd15;
                6'd9:    r = 6'd3;
                6'd11:   r = 6'd19;
                6'd15:   r = 6'd7;
                6'd17:   r = 6'd23;
                6'd19:   r = 6'd11;
                6'd21:   r = 6'd5;
                6'd23:   r = 6'd17;
                6'd25:   r = 6'd25;
                default: r = 6'd0;
            endcase
        end
        else
        begin
            case (v)
                6'd1:    r = 6'd1;
                6'd2:    r = 6'd17;
                6'd4:    r = 6'd25;
                6'd5:    r = 6'd20;
                6'd7:    r = 6'd19;
                6'd8:    r = 6'd29;
                6'd10:   r = 6'd10;
                6'd13:   r = 6'd28;
                6'd14:   r = 6'd26;
                6'd16:   r = 6'd31;
                6'd17:   r = 6'd2;
                6'd19:   r = 6'd7;
                6'd20:   r = 6'd5;
                6'd23:   r = 6'd23;
                6'd25:   r = 6'd4;
                6'd26:   r = 6'd14;
                6'd28:   r = 6'd13;
                6'd29:   r = 6'd8;
                6'd31:   r = 6'd16;
                6'd32:   r = 6'd32;
                default: r = 6'd0;
            endcase
        end
        return r;
    endfunction

    // handshake between stages
    always_comb
    begin
        pop_fire = pop && ser_v_reg;
        at_end   = ser_pos_reg == ser_cnt_reg;
        ser_load = !ser_v_reg || (pop_fire && at_end);
        s2_ready = !s2_v_reg || ser_load;
        s1_ready = !s1_v_reg || s2_ready;
        q_pop    = q_valid && s1_ready;
    end

    // stage 1 math
    always_comb
    begin
        m   = cfg.language ? uac_pkg::EN_M : uac_pkg::RU_M;
        a   = reduce(cfg.mult_key, cfg.language);
        b   = reduce(cfg.shift_key, cfg.language);
        inv = inv_of(a, cfg.language);
        xs  = {1'b0, q_req.idx} + {1'b0, m} - {1'b0, b};
        if (xs >= {1'b0, m})
            xs = xs - {1'b0, m};
        if (cfg.decrypt_mode)
        begin
            k      = inv;
            xp     = xs[5:0];
            addend = 6'd0;
        end
        else
        begin
            k      = a;
            xp     = q_req.idx;
            addend = b;
        end
        prod = k * xp;
        val  = 11'(prod + 12'(addend));
    end

    // stage 2 quotient by reciprocal, exact for values below 1088
    assign rprod = s1_val_reg * (cfg.language ? uac_pkg::EN_RECIP : uac_pkg::RU_RECIP);

    // remainder and re-encoding feeding the serializer
    always_comb
    begin
        qm   = 12'(s2_quo_reg) * 12'(cfg.language ? uac_pkg::EN_M : uac_pkg::RU_M);
        y    = 6'(s2_val_reg - qm[10:0]);
        base = s2_req_reg.upper ? uac_pkg::RU_UP_BASE : uac_pkg::RU_LO_BASE;
        yo   = s2_req_reg.upper ? uac_pkg::RU_UP_YO : uac_pkg::RU_LO_YO;
        if (y < uac_pkg::RU_YO_IDX)
            cp_out = base + 11'(y);
        else if (y == uac_pkg::RU_YO_IDX)
            cp_out = yo;
        else
            cp_out = base + 11'(y) - 11'd1;
        enc = s2_req_reg.data;
        if (s2_req_reg.letter && !s2_bad_reg)
        begin
            if (cfg.language)
                enc[0] = (s2_req_reg.upper ? uac_pkg::ASCII_UP_A : uac_pkg::ASCII_LO_A)
                         + 8'(y);
            else
            begin
                enc[0] = {3'b110, cp_out[10:6]};
                enc[1] = {2'b10, cp_out[5:0]};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg  <= 1'b0;
            s2_v_reg  <= 1'b0;
            ser_v_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
                s1_v_reg <= q_valid;
            if (s2_ready)
                s2_v_reg <= s1_v_reg;
            if (ser_load)
                ser_v_reg <= s2_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready)
        begin
            s1_req_reg <= q_req;
            s1_bad_reg <= inv == 6'd0;
            s1_val_reg <= val;
        end
        if (s2_ready)
        begin
            s2_req_reg <= s1_req_reg;
            s2_bad_reg <= s1_bad_reg;
            s2_val_reg <= s1_val_reg;
            s2_quo_reg <= 6'(rprod >> uac_pkg::RECIP_SHIFT);
        end
        if (ser_load)
        begin
            ser_data_reg <= enc;
            ser_cnt_reg  <= s2_req_reg.cnt;
            ser_last_reg <= s2_req_reg.last;
            ser_bad_reg  <= s2_bad_reg;
            ser_pos_reg  <= 2'd0;
        end
        else if (pop_fire)
            ser_pos_reg <= ser_pos_reg + 2'd1;
    end

    assign empty      = !ser_v_reg;
    assign out_byte   = ser_data_reg[ser_pos_reg];
    assign run_last   = at_end;
    assign stream_end = at_end && ser_last_reg;
    assign key_bad    = ser_bad_reg;

endmodule
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

    localparam int DRAIN_CYCLES = 16;

    typedef logic [3:0][7:0] char_bytes_t;

    typedef struct packed {
        logic [7:0] data;
        logic       run_last;
        logic       stream_end;
        logic       key_bad;
    } out_rec_t;

    logic       clk        = 1'b0;
    logic       rst_n      = 1'b0;
    logic       push       = 1'b0;
    logic [7:0] in_byte    = 8'h00;
    logic       in_last    = 1'b0;
    logic       pop        = 1'b0;
    logic       cfg_valid  = 1'b0;
    logic [1:0] cfg_index  = uac_pkg::CFG_DECRYPT;
    logic [5:0] cfg_data   = 6'd0;
    logic       full;
    logic       empty;
    logic [7:0] out_byte;
    logic       run_last;
    logic       stream_end;
    logic       key_bad;
    logic       cfg_ready;

    // predictor copy of the registers and the character assembler
    logic        dec_r   = 1'b0;
    logic        lang_r  = 1'b0;
    logic [5:0]  mult_r  = 6'd1;
    logic [5:0]  shift_r = 6'd0;
    logic [7:0]  pend [3];
    int unsigned held_cnt = 0;
    int unsigned exp_len  = 0;

    out_rec_t   cipher_q [$];
    logic [7:0] stim_q [$];
    out_rec_t   head_rec;

    int errors     = 0;
    int bytes_in   = 0;
    int bytes_out  = 0;
    int cfg_writes = 0;
    int burst_left = 0;
    int rx_cycle   = 0;
    int rx_stall   = 0;

    utf8_affine_cipher_ru_en u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .in_byte    (in_byte),
        .in_last    (in_last),
        .empty      (empty),
        .pop        (pop),
        .out_byte   (out_byte),
        .run_last   (run_last),
        .stream_end (stream_end),
        .key_bad    (key_bad),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic int unsigned lead_len(logic [7:0] c);
        if (c < 8'h80)
            return 1;
        if ((c & 8'hE0) == 8'hC0)
            return 2;
        if ((c & 8'hF0) == 8'hE0)
            return 3;
        if ((c & 8'hF8) == 8'hF0)
            return 4;
        return 1;
    endfunction

    function automatic int unsigned mod_inverse(int unsigned a, int unsigned m);
        int unsigned i;
        for (i = 1; i < m; i++)
            if ((a * i) % m == 1)
                return i;
        return 0;
    endfunction

    function automatic int unsigned affine_idx(int unsigned x, int unsigned m, int unsigned a,
                                               int unsigned b, int unsigned inv);
        if (dec_r)
            return (inv * ((x + m - b) % m)) % m;
        return (a * x + b) % m;
    endfunction

    // yo sits between ye and zhe, so the code points are not contiguous
    function automatic int unsigned ru_idx(logic [10:0] cp, logic [10:0] base, logic [10:0] yo);
        if (cp == yo)
            return 32'(uac_pkg::RU_YO_IDX);
        if (cp >= base && cp < base + 11'd6)
            return 32'(cp - base);
        if (cp >= base + 11'd6 && cp < base + 11'd32)
            return 32'(cp - base) + 1;
        return 33;
    endfunction

    function automatic logic [10:0] ru_cp(int unsigned x, logic [10:0] base, logic [10:0] yo);
        if (x < 6)
            return base + 11'(x);
        if (x == 6)
            return yo;
        return base + 11'(x) - 11'd1;
    endfunction

    function automatic char_bytes_t map_char(char_bytes_t chr, int unsigned n, int unsigned m,
                                             int unsigned a, int unsigned b, int unsigned inv);
        logic [10:0] cpv;
        int unsigned x;
        int unsigned y;
        if (lang_r)
        begin
            if (n != 1)
                return chr;
            if (chr[0] >= uac_pkg::ASCII_LO_A && chr[0] <= uac_pkg::ASCII_LO_A + 8'd25)
                chr[0] = uac_pkg::ASCII_LO_A
                         + 8'(affine_idx(32'(chr[0] - uac_pkg::ASCII_LO_A), m, a, b, inv));
            else if (chr[0] >= uac_pkg::ASCII_UP_A && chr[0] <= uac_pkg::ASCII_UP_A + 8'd25)
                chr[0] = uac_pkg::ASCII_UP_A
                         + 8'(affine_idx(32'(chr[0] - uac_pkg::ASCII_UP_A), m, a, b, inv));
            return chr;
        end
        if (n != 2)
            return chr;
        if (chr[0] != 8'hD0 && chr[0] != 8'hD1)
            return chr;
        if (chr[1][7:6] != 2'b10)
            return chr;
        cpv = {chr[0][4:0], chr[1][5:0]};
        x = ru_idx(cpv, uac_pkg::RU_LO_BASE, uac_pkg::RU_LO_YO);
        if (x < 33)
        begin
            y = affine_idx(x, m, a, b, inv);
            cpv = ru_cp(y, uac_pkg::RU_LO_BASE, uac_pkg::RU_LO_YO);
        end
        else
        begin
            x = ru_idx(cpv, uac_pkg::RU_UP_BASE, uac_pkg::RU_UP_YO);
            if (x >= 33)
                return chr;
            y = affine_idx(x, m, a, b, inv);
            cpv = ru_cp(y, uac_pkg::RU_UP_BASE, uac_pkg::RU_UP_YO);
        end
        chr[0] = {3'b110, cpv[10:6]};
        chr[1] = {2'b10, cpv[5:0]};
        return chr;
    endfunction

    // runs one accepted byte through the assembler and queues the bytes it releases
    function automatic void predict_byte(logic [7:0] c, logic last);
        char_bytes_t chr;
        int unsigned n;
        int unsigned len;
        int unsigned m;
        int unsigned a;
        int unsigned b;
        int unsigned inv;
        int unsigned i;
        logic        complete;
        logic        bad;
        out_rec_t    r;
        chr = '0;
        if (held_cnt == 0)
        begin
            len = lead_len(c);
            chr[0] = c;
            n = 1;
            complete = (len == 1);
            if (!complete && !last)
            begin
                pend[0] = c;
                held_cnt = 1;
                exp_len = len;
                return;
            end
        end
        else
        begin
            for (i = 0; i < held_cnt; i++)
                chr[i] = pend[i];
            chr[held_cnt] = c;
            n = held_cnt + 1;
            complete = (n >= exp_len);
            if (!complete && !last)
            begin
                if (held_cnt < 3)
                    pend[held_cnt] = c;
                held_cnt++;
                return;
            end
        end
        held_cnt = 0;
        exp_len = 0;
        m = 32'(lang_r ? uac_pkg::EN_M : uac_pkg::RU_M);
        a = 32'(mult_r) % m;
        b = 32'(shift_r) % m;
        inv = mod_inverse(a, m);
        bad = (inv == 0);
        if (complete && !bad)
            chr = map_char(chr, n, m, a, b, inv);
        for (i = 0; i < n; i++)
        begin
            r.data = chr[i];
            r.run_last = (i + 1 == n);
            r.stream_end = (i + 1 == n) && last;
            r.key_bad = bad;
            cipher_q.insert(cipher_q.size(), r);
        end
    endfunction

    task automatic queue_stim(input logic [7:0] v);
        stim_q.insert(stim_q.size(), v);
    endtask

    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        @(negedge clk);
        if (burst_left == 0)
        begin
            gap = ($urandom_range(3) == 0) ? 0 : int'($urandom_range(6, 1));
            burst_left = ($urandom_range(4) == 0) ? 40 : int'($urandom_range(20, 1));
            if (gap > 0)
            begin
                push <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        push <= 1'b1;
        in_byte <= b;
        in_last <= last;
        @(posedge clk);
        while (full) @(posedge clk);
        predict_byte(b, last);
        bytes_in++;
        burst_left--;
    endtask

    task automatic send_stream(input bit cut_ends);
        int i;
        for (i = 0; i < stim_q.size(); i++)
            send_byte(stim_q[i], (i == stim_q.size() - 1) ||
                                 (cut_ends && $urandom_range(39) == 0));
        stim_q.delete();
        @(negedge clk);
        push <= 1'b0;
    endtask

    task automatic drain();
        while (cipher_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [5:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        case (idx)
            uac_pkg::CFG_DECRYPT: dec_r = val[0];
            uac_pkg::CFG_LANG:    lang_r = val[0];
            uac_pkg::CFG_MULT:    mult_r = val;
            uac_pkg::CFG_SHIFT:   shift_r = val;
            default:              ;
        endcase
        cfg_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic configure(input logic dec, input logic lang, input logic [5:0] mult,
                             input logic [5:0] shift);
        drain();
        write_reg(uac_pkg::CFG_DECRYPT, {5'd0, dec});
        write_reg(uac_pkg::CFG_LANG, {5'd0, lang});
        write_reg(uac_pkg::CFG_MULT, mult);
        write_reg(uac_pkg::CFG_SHIFT, shift);
    endtask

    task automatic add_ru_letter(input int unsigned idx, input logic upper);
        logic [10:0] cpv;
        cpv = upper ? ru_cp(idx, uac_pkg::RU_UP_BASE, uac_pkg::RU_UP_YO)
                    : ru_cp(idx, uac_pkg::RU_LO_BASE, uac_pkg::RU_LO_YO);
        queue_stim({3'b110, cpv[10:6]});
        queue_stim({2'b10, cpv[5:0]});
    endtask

    task automatic add_en_letter();
        logic [7:0] first;
        first = $urandom_range(1) ? uac_pkg::ASCII_UP_A : uac_pkg::ASCII_LO_A;
        queue_stim(first + 8'($urandom_range(25)));
    endtask

    // mostly letters of the active alphabet, the rest other text and noise
    task automatic build_text(input int nbytes);
        int kind;
        int len;
        int k;
        while (stim_q.size() < nbytes)
        begin
            kind = $urandom_range(99);
            if (kind < 55)
            begin
                if (lang_r)
                    add_en_letter();
                else
                    add_ru_letter($urandom_range(32), 1'($urandom_range(1)));
            end
            else if (kind < 65)
            begin
                if (lang_r)
                    add_ru_letter($urandom_range(32), 1'($urandom_range(1)));
                else
                    add_en_letter();
            end
            else if (kind < 75)
            begin
                queue_stim(8'($urandom_range(126, 32)));
            end
            else if (kind < 80)
            begin
                // Cyrillic lead with an arbitrary second byte
                queue_stim($urandom_range(1) ? 8'hD1 : 8'hD0);
                queue_stim(8'($urandom_range(255)));
            end
            else if (kind < 90)
            begin
                len = $urandom_range(4, 2);
                case (len)
                    2:       queue_stim(8'hC0 | 8'($urandom_range(31)));
                    3:       queue_stim(8'hE0 | 8'($urandom_range(15)));
                    default: queue_stim(8'hF0 | 8'($urandom_range(7)));
                endcase
                for (k = 1; k < len; k++)
                    queue_stim(8'h80 | 8'($urandom_range(63)));
            end
            else
            begin
                queue_stim(8'($urandom_range(255)));
            end
        end
    endtask

    task automatic test_reset_defaults();
        // identity mapping under reset keys: Pe, er, bang
        stim_q = '{8'hD0, 8'h9F, 8'hD1, 8'h80, 8'h21};
        send_stream(0);
    endtask

    task automatic test_cyrillic_letters();
        configure(1'b0, 1'b0, 6'd5, 6'd32);
        // a, capital yo, capital ya, code point after ya, lone lead flushed at end
        stim_q = '{8'hD0, 8'hB0, 8'hD0, 8'h81, 8'hD0, 8'hAF, 8'hD1, 8'h90, 8'hC3};
        send_stream(0);
        configure(1'b1, 1'b0, 6'd5, 6'd32);
        stim_q = '{8'hD1, 8'h91};
        send_stream(0);
    endtask

    task automatic test_passthrough();
        configure(1'b0, 1'b0, 6'd2, 6'd1);
        // bad lead bytes, 3- and 4-byte characters, truncated character at end
        stim_q = '{8'h00, 8'hFF, 8'h80, 8'hE2, 8'h82, 8'hAC,
                   8'hF0, 8'h9F, 8'h98, 8'h80, 8'hE2, 8'h82};
        send_stream(0);
    endtask

    task automatic test_english();
        configure(1'b1, 1'b1, 6'd63, 6'd63);
        stim_q = '{8'h61, 8'h5A, 8'h5B, 8'hD0, 8'hB0};
        send_stream(0);
    endtask

    task automatic test_bad_keys();
        configure(1'b0, 1'b0, 6'd33, 6'd7);
        stim_q = '{8'hD0, 8'hB0, 8'h78};
        send_stream(0);
        configure(1'b1, 1'b0, 6'd3, 6'd0);
        stim_q = '{8'hD1, 8'h91};
        send_stream(0);
        configure(1'b0, 1'b1, 6'd13, 6'd1);
        stim_q = '{8'h71};
        send_stream(0);
    endtask

    task automatic test_random_text();
        int ph;
        logic [5:0] mult;
        logic [5:0] shift;
        for (ph = 0; ph < 6; ph++)
        begin
            case ($urandom_range(6))
                0:       mult = 6'd0;
                1:       mult = 6'd1;
                2:       mult = 6'd32;
                3:       mult = 6'd63;
                default: mult = 6'($urandom_range(63));
            endcase
            case ($urandom_range(3))
                0:       shift = 6'd0;
                1:       shift = 6'd63;
                default: shift = 6'($urandom_range(63));
            endcase
            configure(1'($urandom_range(1)), 1'(ph % 2), mult, shift);
            build_text(20);
            send_stream(1);
        end
    endtask

    // result side stalls: free-running, random, fixed one-in-three, long holds
    always @(negedge clk)
    begin
        rx_cycle <= rx_cycle + 1;
        case ((rx_cycle / 64) % 4)
            0: pop <= 1'b1;
            1: pop <= ($urandom_range(3) != 0);
            2: pop <= (rx_cycle % 3 == 0);
            default:
                if (rx_stall > 0)
                begin
                    rx_stall <= rx_stall - 1;
                    pop <= 1'b0;
                end
                else if ($urandom_range(9) == 0)
                begin
                    rx_stall <= int'($urandom_range(15, 4));
                    pop <= 1'b0;
                end
                else
                begin
                    pop <= 1'b1;
                end
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            if (cipher_q.size() == 0)
            begin
                $error("unexpected result: out_byte %h", out_byte);
                errors++;
            end
            else
            begin
                head_rec = cipher_q.pop_front();
                bytes_out++;
                if (out_byte !== head_rec.data)
                begin
                    $error("out_byte: expected %h, got %h", head_rec.data, out_byte);
                    errors++;
                end
                if (run_last !== head_rec.run_last)
                begin
                    $error("run_last: expected %b, got %b", head_rec.run_last, run_last);
                    errors++;
                end
                if (stream_end !== head_rec.stream_end)
                begin
                    $error("stream_end: expected %b, got %b", head_rec.stream_end, stream_end);
                    errors++;
                end
                if (key_bad !== head_rec.key_bad)
                begin
                    $error("key_bad: expected %b, got %b", head_rec.key_bad, key_bad);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_reset_defaults();
        test_cyrillic_letters();
        test_passthrough();
        test_english();
        test_bad_keys();
        test_random_text();
        drain();
        $display("Sent %0d bytes, checked %0d result bytes, %0d register writes.",
                 bytes_in, bytes_out, cfg_writes);
        $display("Both alphabets and directions, keys with no inverse, cut and odd characters.");
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== sim.f =====
src/uac_pkg.sv
src/uac_front.sv
src/uac_queue.sv
src/uac_back.sv
src/utf8_affine_cipher_ru_en.sv
tb/sv/tb_top.sv
